/* hdl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

   // fixed widths of the request and response fields
   localparam int TYPE_W  = 3;
   localparam int INDEX_W = 11;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   // internal position width, wide enough for any supported capacity and its count
   localparam int POS_W = 13;

   typedef enum logic [TYPE_W-1:0] {
      REQ_READ = 3'd0,
      REQ_HEAD = 3'd1,
      REQ_TAIL = 3'd2,
      REQ_AT   = 3'd3,
      REQ_DEL  = 3'd4
   } req_code_type;

   // shift command broadcast to every cell of the chain
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   // number of radix-4 levels needed to reduce the given number of leaves
   function automatic int tree_levels(input int leaves);
      return ($clog2(leaves) + 1) / 2;
   endfunction

endpackage

`default_nettype wire

/* hdl/ils_req_if.sv */
`default_nettype none

interface ils_req_if
   import ils_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [TYPE_W-1:0]        req_type;
   logic [INDEX_W-1:0]       index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output index, output value, input ready);
   modport sink (input valid, input req_type, input index, input value, output ready);
endinterface

`default_nettype wire

/* hdl/ils_rsp_if.sv */
`default_nettype none

interface ils_rsp_if
   import ils_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic                     ok;
   logic [COUNT_W-1:0]       count;

   modport source (output valid, output read_value, output ok, output count, input ready);
   modport sink (input valid, input read_value, input ok, input count, output ready);
endinterface

`default_nettype wire

/* hdl/ils_cell.sv */
`default_nettype none

module ils_cell
   import ils_pkg::*;
#(
   parameter int unsigned POS = 0
) (
   input  wire logic                clock,
   input  wire cell_cmd_type        cmd,
   input  wire logic [DATA_W-1:0]   left_data,
   input  wire logic [DATA_W-1:0]   right_data,
   input  wire logic [POS_W-1:0]    sel_pos,
   output logic      [DATA_W-1:0]   entry,
   output logic      [DATA_W-1:0]   leaf
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.ins && (MY_POS > cmd.pos)) begin
         entry_in = left_data;
      end else if (cmd.ins && (MY_POS == cmd.pos)) begin
         entry_in = cmd.value;
      end else if (cmd.del && (MY_POS >= cmd.pos)) begin
         entry_in = right_data;
      end else begin
         // no shift reaches this cell, hold the word
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // only the selected cell drives its word into the read tree
   assign leaf  = (MY_POS == sel_pos) ? entry_ff : '0;

endmodule

`default_nettype wire

/* hdl/ils_read_tree.sv */
`default_nettype none

module ils_read_tree
   import ils_pkg::*;
#(
   parameter int unsigned LEAVES = 1024
) (
   input  wire logic              clock,
   input  wire logic [DATA_W-1:0] leaf [LEAVES],
   output logic      [DATA_W-1:0] root
);

   localparam int LEVELS = tree_levels(LEAVES);
   localparam int PAD    = 1 << (2 * LEVELS);

   logic [DATA_W-1:0] pad_leaf [PAD];
   logic [DATA_W-1:0] node_ff  [1:LEVELS][PAD/4];

   for (genvar i = 0; i < PAD; i++) begin : g_pad
      if (i < LEAVES) begin : g_real
         assign pad_leaf[i] = leaf[i];
      end else begin : g_zero
         assign pad_leaf[i] = '0;
      end
   end

   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      for (genvar j = 0; j < (PAD >> (2 * l)); j++) begin : g_node
         if (l == 1) begin : g_first
            always_ff @(posedge clock) begin
               node_ff[l][j] <= pad_leaf[4*j] | pad_leaf[4*j+1]
                              | pad_leaf[4*j+2] | pad_leaf[4*j+3];
            end
         end else begin : g_upper
            always_ff @(posedge clock) begin
               node_ff[l][j] <= node_ff[l-1][4*j] | node_ff[l-1][4*j+1]
                              | node_ff[l-1][4*j+2] | node_ff[l-1][4*j+3];
            end
         end
      end
   end

   assign root = node_ff[LEVELS][0];

endmodule

`default_nettype wire

/* hdl/indexed_list_store_core.sv */
`default_nettype none

// channel   port    dir   fields
// request   req_ch  in    req_type[2:0], index[10:0], value[31:0] signed
// response  rsp_ch  out   read_value[31:0] signed, ok, count[10:0]
//
// one request in flight; a new request waits until the response of the last one is taken,
// LEVELS = ceil(log4(CAPACITY)) registered stages of the read tree
// accepted inserts and deletes shift the cells from the target position to the tail at the accept edge
// reset clears the entry count and the handshake state; cell contents are left as is
// a new request is taken in the cycle the pending response is taken

module indexed_list_store_core
   import ils_pkg::*;
#(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ils_req_if.sink     req_ch,
   ils_rsp_if.source   rsp_ch
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int WAIT_W = $clog2(LEVELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_RESP
   } state_type;

   state_type         state_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [POS_W-1:0]  sel_pos_ff;
   logic              rd_hit_ff;
   logic              ok_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_ok_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // request decode
   logic              accept;
   logic [POS_W-1:0]  req_pos;
   logic [POS_W-1:0]  cur_count;
   logic [POS_W-1:0]  ins_pos;
   logic              is_ins;
   logic              is_del;
   logic              is_read;
   logic              ins_ok;
   logic              del_ok;
   logic              rd_ok;
   cell_cmd_type      cmd;

   // chain and read tree
   logic [DATA_W-1:0] entry [CAPACITY];
   logic [DATA_W-1:0] leaf  [CAPACITY];
   logic [DATA_W-1:0] root;

   assign req_ch.ready = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign req_pos   = POS_W'(req_ch.index);
   assign cur_count = POS_W'(count_ff);

   always_comb begin
      is_ins  = 1'b0;
      is_del  = 1'b0;
      is_read = 1'b0;
      ins_pos = req_pos;
      unique case (req_ch.req_type)
         REQ_READ: is_read = 1'b1;
         REQ_HEAD: begin
            is_ins  = 1'b1;
            ins_pos = '0;
         end
         REQ_TAIL: begin
            is_ins  = 1'b1;
            ins_pos = cur_count;
         end
         REQ_AT:   is_ins = 1'b1;
         REQ_DEL:  is_del = 1'b1;
         default:  ;  // unknown request codes change nothing
      endcase
   end

   // full list rejects any insert, insert may land one past the last entry
   assign ins_ok = is_ins && (cur_count != POS_W'(CAPACITY)) && (ins_pos <= cur_count);
   assign del_ok = is_del && (req_pos < cur_count);
   assign rd_ok  = is_read && (req_pos < cur_count);

   assign cmd.ins   = accept && ins_ok;
   assign cmd.del   = accept && del_ok;
   assign cmd.pos   = is_del ? req_pos : ins_pos;
   assign cmd.value = req_ch.value;

   // chain of cells, cell 0 holds the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = entry[i];
      end else begin : g_mid_r
         assign right_data = entry[i+1];
      end

      ils_cell #(
         .POS (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .sel_pos    (sel_pos_ff),
         .entry      (entry[i]),
         .leaf       (leaf[i])
      );
   end

   // or-reduction of the selected cell, LEVELS registered stages
   ils_read_tree #(
      .LEAVES (CAPACITY)
   ) u_read_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            state_ff <= ST_BUSY;
            wait_ff  <= '0;
            if (ins_ok) begin
               count_ff <= CNT_W'(count_ff + 1'b1);
            end else if (del_ok) begin
               count_ff <= CNT_W'(count_ff - 1'b1);
            end
         end else begin
            unique case (state_ff)
               ST_IDLE: ;
               ST_BUSY: begin
                  // tree root is valid once every stage has seen the selected leaf
                  if (wait_ff == WAIT_W'(LEVELS)) begin
                     state_ff <= ST_RESP;
                  end else begin
                     wait_ff <= WAIT_W'(wait_ff + 1'b1);
                  end
               end
               ST_RESP: begin
                  if (rsp_ch.ready) begin
                     state_ff <= ST_IDLE;
                  end
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end

      // request bookkeeping, no reset needed
      if (accept) begin
         sel_pos_ff <= req_pos;
         rd_hit_ff  <= rd_ok;
         ok_ff      <= ins_ok || del_ok || rd_ok;
      end

      // response register loaded when the tree result is ready
      if ((state_ff == ST_BUSY) && (wait_ff == WAIT_W'(LEVELS))) begin
         rsp_value_ff <= rd_hit_ff ? root : '1;
         rsp_ok_ff    <= ok_ff;
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   assign rsp_ch.valid      = (state_ff == ST_RESP);
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.ok         = rsp_ok_ff;
   assign rsp_ch.count      = rsp_count_ff;

endmodule

`default_nettype wire
